// ----- rtl/wdpc_pkg.sv -----
// ----------------------------------------------------------------------------
// wdpc_pkg
// shared widths, codes and constants of the wall distance pid controller
// ----------------------------------------------------------------------------
package wdpc_pkg;

    localparam int GAIN_W    = 16;
    localparam int EFFORT_W  = 10;
    localparam int ERROR_W   = 11;
    localparam int DT_W      = 16;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam int EFFORT_CLAMP      = 300;
    localparam int ALL_SWITCH_TARGET = 130;
    localparam int DERIV_SCALE       = 1000;

    localparam logic [FUNC_W-1:0] FUNC_FRONT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BACK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ALL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } term_t;

endpackage

// ----- rtl/wdpc_if.sv -----
// ----------------------------------------------------------------------------
// wdpc interfaces
// valid/ready channels for step requests, results and gain writes
// ----------------------------------------------------------------------------
interface wdpc_step_if #(
    parameter int SENSOR_WIDTH = 10
);
    import wdpc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic                    side;
    logic [SENSOR_WIDTH-1:0] target_distance;
    logic [SENSOR_WIDTH-1:0] front_left_reading;
    logic [SENSOR_WIDTH-1:0] front_right_reading;
    logic [SENSOR_WIDTH-1:0] back_left_reading;
    logic [SENSOR_WIDTH-1:0] back_right_reading;
    logic [DT_W-1:0]         elapsed_ms;

    modport source (
        output valid, func, side, target_distance, front_left_reading,
               front_right_reading, back_left_reading, back_right_reading, elapsed_ms,
        input  ready
    );

    modport sink (
        input  valid, func, side, target_distance, front_left_reading,
               front_right_reading, back_left_reading, back_right_reading, elapsed_ms,
        output ready
    );
endinterface

interface wdpc_result_if;
    import wdpc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ERROR_W-1:0]  error;
    logic signed [EFFORT_W-1:0] front_effort;
    logic signed [EFFORT_W-1:0] back_effort;
    logic signed [EFFORT_W-1:0] all_effort;

    modport source (
        output valid, error, front_effort, back_effort, all_effort,
        input  ready
    );

    modport sink (
        input  valid, error, front_effort, back_effort, all_effort,
        output ready
    );
endinterface

interface wdpc_cfg_if;
    import wdpc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- rtl/wall_distance_pid_controller.sv -----
// ----------------------------------------------------------------------------
// wall_distance_pid_controller
// one request at a time: a new one is taken only when idle, after the last result
// is registered; the work is a bit-serial divide (SENSOR_WIDTH + 10 steps)
// and three 16-step multiplies on one adder
// async reset clears gains, integrators, efforts and previous error to zero
// ----------------------------------------------------------------------------
module wall_distance_pid_controller #(
    parameter int INTEGRATOR_WIDTH = 32,
    parameter int SENSOR_WIDTH     = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    wdpc_step_if.sink     step,
    wdpc_result_if.source result,
    wdpc_cfg_if.sink      cfg
);
    import wdpc_pkg::*;

    localparam int IW   = INTEGRATOR_WIDTH;
    localparam int SW   = SENSOR_WIDTH;
    localparam int EW   = SW + 1;
    localparam int NW   = SW + 10;
    localparam int DW   = NW + 1;
    localparam int XW   = ((IW > EW) ? IW : EW) + 1;
    localparam int MW   = (IW > DW) ? IW : DW;
    localparam int SUMW = MW + GAIN_W + 2;
    localparam int QW   = SUMW - 8;
    localparam int CW   = $clog2(NW) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_MUL,
        S_FINISH
    } state_t;

    state_t state_reg;

    logic [FUNC_W-1:0] func_reg;
    logic              side_reg;
    logic [SW-1:0]     target_reg;
    logic [SW-1:0]     fl_reg;
    logic [SW-1:0]     fr_reg;
    logic [SW-1:0]     bl_reg;
    logic [SW-1:0]     br_reg;
    logic [DT_W-1:0]   dt_reg;

    logic signed [GAIN_W-1:0]   gain_p_reg;
    logic signed [GAIN_W-1:0]   gain_i_reg;
    logic signed [GAIN_W-1:0]   gain_d_reg;
    logic signed [IW-1:0]       integ_all_reg;
    logic signed [IW-1:0]       integ_front_reg;
    logic signed [IW-1:0]       integ_back_reg;
    logic signed [EW-1:0]       prev_error_reg;
    logic signed [EFFORT_W-1:0] effort_all_reg;
    logic signed [EFFORT_W-1:0] effort_front_reg;
    logic signed [EFFORT_W-1:0] effort_back_reg;

    logic signed [EW-1:0]   e_reg;
    logic [NW-1:0]          quo_reg;
    logic [DT_W-1:0]        rem_reg;
    logic                   neg_reg;
    logic [CW-1:0]          cnt_reg;
    term_t                  term_reg;
    logic signed [SUMW-1:0] acc_reg;
    logic signed [SUMW-1:0] mcand_reg;
    logic [GAIN_W-1:0]      mplier_reg;

    logic                       out_valid_reg;
    logic signed [ERROR_W-1:0]  out_error_reg;
    logic signed [EFFORT_W-1:0] out_front_reg;
    logic signed [EFFORT_W-1:0] out_back_reg;
    logic signed [EFFORT_W-1:0] out_all_reg;

    logic signed [EW-1:0]       sel_error;
    logic [EW-1:0]              mag_e;
    logic [EW-1:0]              mag_prev;
    logic signed [EW-1:0]       diff;
    logic [EW-1:0]              diff_mag;
    logic [NW-1:0]              dividend;
    logic [DT_W-1:0]            dt_eff;
    logic [DT_W:0]              trial;
    logic [SUMW-1:0]            alu_a;
    logic [SUMW-1:0]            alu_b;
    logic                       alu_sub;
    logic [SUMW-1:0]            alu_sum;
    logic                       div_fits;
    logic signed [SUMW-1:0]     mul_acc;
    logic signed [IW-1:0]       integ_sel;
    logic signed [DW-1:0]       d_val;
    logic signed [QW-1:0]       shifted;
    logic signed [EFFORT_W-1:0] effort_new;
    logic                       finish_go;
    logic signed [EFFORT_W-1:0] effort_front_next;
    logic signed [EFFORT_W-1:0] effort_back_next;
    logic signed [EFFORT_W-1:0] effort_all_next;
    logic signed [EW+ERROR_W-1:0] e_wide;

    function automatic logic signed [IW-1:0] integrate(
        input logic signed [IW-1:0]       acc,
        input logic signed [EW-1:0]       e,
        input logic signed [EFFORT_W-1:0] eff
    );
        logic signed [XW-1:0] s;
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        s  = $signed({{(XW-IW){acc[IW-1]}}, acc}) + $signed({{(XW-EW){e[EW-1]}}, e});
        hi = $signed({{(XW-IW+1){1'b0}}, {(IW-1){1'b1}}});
        lo = $signed({{(XW-IW+1){1'b1}}, {(IW-1){1'b0}}});
        if (eff >= EFFORT_W'(EFFORT_CLAMP) || eff <= EFFORT_W'(-EFFORT_CLAMP))
        begin
            integrate = acc;
        end
        else if (s > hi)
        begin
            integrate = hi[IW-1:0];
        end
        else if (s < lo)
        begin
            integrate = lo[IW-1:0];
        end
        else
        begin
            integrate = s[IW-1:0];
        end
    endfunction

    wdpc_select #(
        .SENSOR_WIDTH(SW)
    ) u_select (
        .func                (func_reg),
        .side                (side_reg),
        .target_distance     (target_reg),
        .front_left_reading  (fl_reg),
        .front_right_reading (fr_reg),
        .back_left_reading   (bl_reg),
        .back_right_reading  (br_reg),
        .error               (sel_error)
    );

    // derivative numerator
    assign mag_e    = sel_error[EW-1] ? EW'(-sel_error) : EW'(sel_error);
    assign mag_prev = prev_error_reg[EW-1] ? EW'(-prev_error_reg) : EW'(prev_error_reg);
    assign diff     = $signed(mag_e) - $signed(mag_prev);
    assign diff_mag = diff[EW-1] ? EW'(-diff) : EW'(diff);
    assign dividend = NW'(diff_mag[SW-1:0]) * NW'(DERIV_SCALE);
    assign dt_eff   = (dt_reg == '0) ? DT_W'(1) : dt_reg;

    // shared adder: restoring divide step or shift-add multiply step
    assign trial   = {rem_reg, quo_reg[NW-1]};
    assign alu_a   = (state_reg == S_DIV) ? SUMW'(trial) : acc_reg;
    assign alu_b   = (state_reg == S_DIV) ? SUMW'(dt_reg) : mcand_reg;
    assign alu_sub = (state_reg == S_DIV) ? 1'b1 : (cnt_reg == CW'(GAIN_W - 1));

    wdpc_alu #(
        .WIDTH(SUMW)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    assign div_fits = ~alu_sum[SUMW-1];
    assign mul_acc  = mplier_reg[0] ? $signed(alu_sum) : acc_reg;

    always_comb
    begin
        case (func_reg)
            FUNC_FRONT: integ_sel = integ_front_reg;
            FUNC_BACK:  integ_sel = integ_back_reg;
            default:    integ_sel = integ_all_reg;
        endcase
    end

    assign d_val = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    // floor shift by 8, then clamp
    assign shifted = acc_reg[SUMW-1:8];

    always_comb
    begin
        if (shifted > QW'(EFFORT_CLAMP))
        begin
            effort_new = EFFORT_W'(EFFORT_CLAMP);
        end
        else if (shifted < QW'(-EFFORT_CLAMP))
        begin
            effort_new = EFFORT_W'(-EFFORT_CLAMP);
        end
        else
        begin
            effort_new = shifted[EFFORT_W-1:0];
        end
    end

    assign finish_go = (state_reg == S_FINISH) && (!out_valid_reg || result.ready);

    always_comb
    begin
        effort_front_next = effort_front_reg;
        effort_back_next  = effort_back_reg;
        effort_all_next   = effort_all_reg;
        if (finish_go)
        begin
            case (func_reg)
                FUNC_FRONT: effort_front_next = effort_new;
                FUNC_BACK:  effort_back_next  = effort_new;
                default:    effort_all_next   = effort_new;
            endcase
        end
    end

    assign e_wide = {{ERROR_W{e_reg[EW-1]}}, e_reg};

    // control, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            term_reg         <= TERM_P;
            integ_all_reg    <= '0;
            integ_front_reg  <= '0;
            integ_back_reg   <= '0;
            prev_error_reg   <= '0;
            effort_all_reg   <= '0;
            effort_front_reg <= '0;
            effort_back_reg  <= '0;
            out_valid_reg    <= 1'b0;
            out_error_reg    <= '0;
            out_front_reg    <= '0;
            out_back_reg     <= '0;
            out_all_reg      <= '0;
        end
        else
        begin
            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            effort_front_reg <= effort_front_next;
            effort_back_reg  <= effort_back_next;
            effort_all_reg   <= effort_all_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (step.valid)
                    begin
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    integ_all_reg   <= integrate(integ_all_reg, sel_error, effort_all_reg);
                    integ_front_reg <= integrate(integ_front_reg, sel_error, effort_front_reg);
                    integ_back_reg  <= integrate(integ_back_reg, sel_error, effort_back_reg);
                    prev_error_reg  <= sel_error;
                    cnt_reg         <= '0;
                    state_reg       <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == CW'(NW - 1))
                    begin
                        cnt_reg   <= '0;
                        term_reg  <= TERM_P;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_MUL:
                begin
                    if (cnt_reg == CW'(GAIN_W - 1))
                    begin
                        cnt_reg <= '0;
                        case (term_reg)
                            TERM_P:  term_reg  <= TERM_I;
                            TERM_I:  term_reg  <= TERM_D;
                            default: state_reg <= S_FINISH;
                        endcase
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_FINISH:
                begin
                    if (finish_go)
                    begin
                        out_error_reg <= e_wide[ERROR_W-1:0];
                        out_front_reg <= effort_front_next;
                        out_back_reg  <= effort_back_next;
                        out_all_reg   <= effort_all_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_GAIN_P: gain_p_reg <= $signed(cfg.data);
                CFG_GAIN_I: gain_i_reg <= $signed(cfg.data);
                CFG_GAIN_D: gain_d_reg <= $signed(cfg.data);
                default:    ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (step.valid)
                begin
                    func_reg   <= step.func;
                    side_reg   <= step.side;
                    target_reg <= step.target_distance;
                    fl_reg     <= step.front_left_reading;
                    fr_reg     <= step.front_right_reading;
                    bl_reg     <= step.back_left_reading;
                    br_reg     <= step.back_right_reading;
                    dt_reg     <= step.elapsed_ms;
                end
            end
            S_SETUP:
            begin
                e_reg   <= sel_error;
                quo_reg <= dividend;
                rem_reg <= '0;
                neg_reg <= diff[EW-1];
                dt_reg  <= dt_eff;
            end
            S_DIV:
            begin
                rem_reg <= div_fits ? alu_sum[DT_W-1:0] : trial[DT_W-1:0];
                quo_reg <= {quo_reg[NW-2:0], div_fits};
                if (cnt_reg == CW'(NW - 1))
                begin
                    acc_reg    <= '0;
                    mcand_reg  <= $signed({{(SUMW-EW){e_reg[EW-1]}}, e_reg});
                    mplier_reg <= gain_p_reg;
                end
            end
            S_MUL:
            begin
                acc_reg <= mul_acc;
                if (cnt_reg == CW'(GAIN_W - 1) && term_reg == TERM_P)
                begin
                    mcand_reg  <= $signed({{(SUMW-IW){integ_sel[IW-1]}}, integ_sel});
                    mplier_reg <= gain_i_reg;
                end
                else if (cnt_reg == CW'(GAIN_W - 1) && term_reg == TERM_I)
                begin
                    mcand_reg  <= $signed({{(SUMW-DW){d_val[DW-1]}}, d_val});
                    mplier_reg <= gain_d_reg;
                end
                else
                begin
                    mcand_reg  <= mcand_reg <<< 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign step.ready          = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.error        = out_error_reg;
    assign result.front_effort = out_front_reg;
    assign result.back_effort  = out_back_reg;
    assign result.all_effort   = out_all_reg;

    ap_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        step.valid && step.ready |=> state_reg == S_SETUP)
        else $error("accepted request did not start setup");

    ap_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish");

    ap_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg < CW'(NW))
        else $error("divide step count out of range");

    ap_effort_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        effort_front_reg <= EFFORT_W'(EFFORT_CLAMP) && effort_front_reg >= EFFORT_W'(-EFFORT_CLAMP)
        && effort_back_reg <= EFFORT_W'(EFFORT_CLAMP) && effort_back_reg >= EFFORT_W'(-EFFORT_CLAMP)
        && effort_all_reg <= EFFORT_W'(EFFORT_CLAMP) && effort_all_reg >= EFFORT_W'(-EFFORT_CLAMP))
        else $error("effort register outside clamp");
endmodule

// ----- rtl/wdpc_alu.sv -----
// ----------------------------------------------------------------------------
// wdpc_alu
// shared add/subtract unit for the divide and multiply steps
// ----------------------------------------------------------------------------
module wdpc_alu #(
    parameter int WIDTH = 50
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum
);
    logic [WIDTH-1:0] b_op;

    assign b_op = sub ? ~b : b;
    assign sum  = a + b_op + {{(WIDTH-1){1'b0}}, sub};
endmodule

// ----- rtl/wdpc_select.sv -----
// ----------------------------------------------------------------------------
// wdpc_select
// sensor selection by mode and side, signed distance error
// ----------------------------------------------------------------------------
module wdpc_select #(
    parameter int SENSOR_WIDTH = 10
) (
    input  logic [wdpc_pkg::FUNC_W-1:0] func,
    input  logic                        side,
    input  logic [SENSOR_WIDTH-1:0]     target_distance,
    input  logic [SENSOR_WIDTH-1:0]     front_left_reading,
    input  logic [SENSOR_WIDTH-1:0]     front_right_reading,
    input  logic [SENSOR_WIDTH-1:0]     back_left_reading,
    input  logic [SENSOR_WIDTH-1:0]     back_right_reading,
    output logic signed [SENSOR_WIDTH:0] error
);
    import wdpc_pkg::*;

    localparam int EW = SENSOR_WIDTH + 1;

    logic                    use_front;
    logic [SENSOR_WIDTH-1:0] reading;
    logic signed [EW-1:0]    target_s;
    logic signed [EW-1:0]    reading_s;

    always_comb
    begin
        case (func)
            FUNC_FRONT: use_front = 1'b1;
            FUNC_BACK:  use_front = 1'b0;
            default:    use_front = {1'b0, target_distance} < EW'(ALL_SWITCH_TARGET);
        endcase
    end

    always_comb
    begin
        if (use_front)
        begin
            reading = side ? front_right_reading : front_left_reading;
        end
        else
        begin
            reading = side ? back_right_reading : back_left_reading;
        end
    end

    assign target_s  = $signed({1'b0, target_distance});
    assign reading_s = $signed({1'b0, reading});
    // right side: target minus reading, left side negated
    assign error     = side ? (target_s - reading_s) : (reading_s - target_s);
endmodule

// ----- tb/tb_wall_distance_pid_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wall_distance_pid_controller
// Drives control step requests through the valid/ready step channel and
// checks every result against an in-bench PID predictor. The predictor keeps
// its own gains, integrators, previous error and effort registers. Gains are
// loaded between phases while the controller is idle, including the extreme
// positive, negative and zero settings. Both handshake sides idle at random outside the steady phase.
// ----------------------------------------------------------------------------
module tb_wall_distance_pid_controller;
    import wdpc_pkg::*;

    localparam int     SENSOR_W     = 10;
    localparam int     INTEG_W      = 32;
    localparam longint INTEG_MAX    = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN    = -INTEG_MAX - 1;
    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     RANDOM_STEPS = 125;
    localparam int     PRINT_CAP    = 40;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic                side;
        logic [SENSOR_W-1:0] target;
        logic [SENSOR_W-1:0] front_left;
        logic [SENSOR_W-1:0] front_right;
        logic [SENSOR_W-1:0] back_left;
        logic [SENSOR_W-1:0] back_right;
        logic [DT_W-1:0]     elapsed;
    } step_req_t;

    typedef struct packed {
        logic signed [ERROR_W-1:0]  error;
        logic signed [EFFORT_W-1:0] front_effort;
        logic signed [EFFORT_W-1:0] back_effort;
        logic signed [EFFORT_W-1:0] all_effort;
    } step_res_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [GAIN_W-1:0]    data;
    } gain_write_t;

    logic clk = 1'b0;
    logic rst_n;

    wdpc_step_if #(.SENSOR_WIDTH(SENSOR_W)) step_if ();
    wdpc_result_if result_if ();
    wdpc_cfg_if cfg_if ();

    wall_distance_pid_controller #(
        .INTEGRATOR_WIDTH (INTEG_W),
        .SENSOR_WIDTH     (SENSOR_W)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always #6 clk = ~clk;

    step_req_t   pending_steps[$];
    step_res_t   predicted_steps[$];
    gain_write_t gain_writes[$];
    step_req_t   step_on_bus;
    gain_write_t gain_on_bus;

    longint kp, ki, kd;
    longint integ_front, integ_back, integ_all;
    longint last_error;
    longint eff_front, eff_back, eff_all;

    int  steps_queued   = 0;
    int  steps_taken    = 0;
    int  results_seen   = 0;
    int  gains_queued   = 0;
    int  gains_taken    = 0;
    int  gain_settings  = 0;
    int  error_count    = 0;
    int  cycle_count    = 0;
    bit  steady         = 1'b0;

    function automatic longint integ_update(input longint acc, input longint e,
                                            input longint eff);
        longint s;
        if (eff >= EFFORT_CLAMP || eff <= -EFFORT_CLAMP)
            return acc;
        s = acc + e;
        if (s > INTEG_MAX)
            s = INTEG_MAX;
        if (s < INTEG_MIN)
            s = INTEG_MIN;
        return s;
    endfunction

    function automatic step_res_t predict_pid_step(input step_req_t r);
        longint    tgt, rd, e, d, dt, acc, s, q;
        logic      use_front;
        step_res_t res;
        tgt = longint'(r.target);
        case (r.func)
            FUNC_FRONT: use_front = 1'b1;
            FUNC_BACK:  use_front = 1'b0;
            default:    use_front = (tgt < ALL_SWITCH_TARGET);
        endcase
        if (use_front)
            rd = longint'(r.side ? r.front_right : r.front_left);
        else
            rd = longint'(r.side ? r.back_right : r.back_left);
        e = r.side ? (tgt - rd) : (rd - tgt);

        // anti-windup uses the effort registers from before this step
        integ_all   = integ_update(integ_all, e, eff_all);
        integ_front = integ_update(integ_front, e, eff_front);
        integ_back  = integ_update(integ_back, e, eff_back);

        dt = (r.elapsed == '0) ? longint'(1) : longint'(r.elapsed);
        d = (((e < 0) ? -e : e) - ((last_error < 0) ? -last_error : last_error))
            * DERIV_SCALE / dt;
        last_error = e;

        case (r.func)
            FUNC_FRONT: acc = integ_front;
            FUNC_BACK:  acc = integ_back;
            default:    acc = integ_all;
        endcase
        s = kp * e + ki * acc + kd * d;
        q = s >>> 8;
        if (q > EFFORT_CLAMP)
            q = EFFORT_CLAMP;
        if (q < -EFFORT_CLAMP)
            q = -EFFORT_CLAMP;
        case (r.func)
            FUNC_FRONT: eff_front = q;
            FUNC_BACK:  eff_back  = q;
            default:    eff_all   = q;
        endcase

        res.error        = e[ERROR_W-1:0];
        res.front_effort = eff_front[EFFORT_W-1:0];
        res.back_effort  = eff_back[EFFORT_W-1:0];
        res.all_effort   = eff_all[EFFORT_W-1:0];
        return res;
    endfunction

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 32);
    endfunction

    function automatic logic [SENSOR_W-1:0] near(input int tgt);
        int v;
        v = tgt + int'($urandom_range(0, 80)) - 40;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[SENSOR_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_step(input logic [FUNC_W-1:0] f, input logic sd,
                              input int tgt, input int fl, input int fr,
                              input int bl, input int br, input int dt);
        step_req_t r;
        r.func        = f;
        r.side        = sd;
        r.target      = tgt[SENSOR_W-1:0];
        r.front_left  = fl[SENSOR_W-1:0];
        r.front_right = fr[SENSOR_W-1:0];
        r.back_left   = bl[SENSOR_W-1:0];
        r.back_right  = br[SENSOR_W-1:0];
        r.elapsed     = dt[DT_W-1:0];
        pending_steps.push_back(r);
        steps_queued++;
    endtask

    task automatic wait_drained();
        while (steps_taken != steps_queued || predicted_steps.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                              input logic [GAIN_W-1:0] dd);
        // let the last request fully retire before touching the gains
        repeat (4) @(posedge clk);
        gain_writes.push_back('{CFG_GAIN_P, p});
        gain_writes.push_back('{CFG_GAIN_I, i});
        gain_writes.push_back('{CFG_GAIN_D, dd});
        gains_queued += 3;
        while (gains_taken != gains_queued)
            @(posedge clk);
        gain_settings++;
    endtask

    // step request driver
    always @(posedge clk) begin : step_driver
        step_req_t nxt;
        if (!rst_n) begin
            step_if.valid <= 1'b0;
        end
        else begin
            if (step_if.valid && step_if.ready) begin
                predicted_steps.push_back(predict_pid_step(step_on_bus));
                steps_taken++;
            end
            if (!step_if.valid || step_if.ready) begin
                if (pending_steps.size() != 0 && !take_break()) begin
                    nxt = pending_steps.pop_front();
                    step_on_bus                 = nxt;
                    step_if.func                <= nxt.func;
                    step_if.side                <= nxt.side;
                    step_if.target_distance     <= nxt.target;
                    step_if.front_left_reading  <= nxt.front_left;
                    step_if.front_right_reading <= nxt.front_right;
                    step_if.back_left_reading   <= nxt.back_left;
                    step_if.back_right_reading  <= nxt.back_right;
                    step_if.elapsed_ms          <= nxt.elapsed;
                    step_if.valid               <= 1'b1;
                end
                else begin
                    step_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : result_monitor
        step_res_t want;
        if (!rst_n) begin
            result_if.ready <= 1'b0;
        end
        else begin
            if (result_if.valid && result_if.ready) begin
                if (predicted_steps.size() == 0) begin
                    report_mismatch("result with no request pending");
                end
                else begin
                    want = predicted_steps.pop_front();
                    results_seen++;
                    if (result_if.error !== want.error)
                        report_mismatch($sformatf("result %0d error got %0d want %0d",
                            results_seen, result_if.error, want.error));
                    if (result_if.front_effort !== want.front_effort)
                        report_mismatch($sformatf("result %0d front_effort got %0d want %0d",
                            results_seen, result_if.front_effort, want.front_effort));
                    if (result_if.back_effort !== want.back_effort)
                        report_mismatch($sformatf("result %0d back_effort got %0d want %0d",
                            results_seen, result_if.back_effort, want.back_effort));
                    if (result_if.all_effort !== want.all_effort)
                        report_mismatch($sformatf("result %0d all_effort got %0d want %0d",
                            results_seen, result_if.all_effort, want.all_effort));
                end
            end
            result_if.ready <= !take_break();
        end
    end

    // gain write driver
    always @(posedge clk) begin : gain_writer
        gain_write_t w;
        if (!rst_n) begin
            cfg_if.valid <= 1'b0;
        end
        else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (gain_on_bus.index)
                    CFG_GAIN_P: kp = longint'($signed(gain_on_bus.data));
                    CFG_GAIN_I: ki = longint'($signed(gain_on_bus.data));
                    CFG_GAIN_D: kd = longint'($signed(gain_on_bus.data));
                    default: ;
                endcase
                gains_taken++;
            end
            if (!cfg_if.valid || cfg_if.ready) begin
                if (gain_writes.size() != 0) begin
                    w = gain_writes.pop_front();
                    gain_on_bus   = w;
                    cfg_if.index <= w.index;
                    cfg_if.data  <= w.data;
                    cfg_if.valid <= 1'b1;
                end
                else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("wall_distance_pid_controller test failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [FUNC_W-1:0] modes[4];
        logic [GAIN_W-1:0] gp, gi, gd;
        int                tgt, kind, dt, fl, fr, bl, br;
        logic [FUNC_W-1:0] f;

        modes = '{FUNC_FRONT, FUNC_BACK, FUNC_ALL, FUNC_SPARE};
        kp = 0;
        ki = 0;
        kd = 0;
        integ_front = 0;
        integ_back  = 0;
        integ_all   = 0;
        last_error  = 0;
        eff_front   = 0;
        eff_back    = 0;
        eff_all     = 0;

        rst_n                       = 1'b0;
        step_if.valid               = 1'b0;
        step_if.func                = '0;
        step_if.side                = 1'b0;
        step_if.target_distance     = '0;
        step_if.front_left_reading  = '0;
        step_if.front_right_reading = '0;
        step_if.back_left_reading   = '0;
        step_if.back_right_reading  = '0;
        step_if.elapsed_ms          = '0;
        result_if.ready             = 1'b0;
        cfg_if.valid                = 1'b0;
        cfg_if.index                = '0;
        cfg_if.data                 = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        load_gains(16'sd256, 16'sd16, 16'sd32);
        foreach (modes[m]) begin
            queue_step(modes[m], 1'b0, 500, 400, 600, 300, 700, 10);
            queue_step(modes[m], 1'b1, 500, 400, 600, 300, 700, 10);
        end
        // all mode just below and at the front/rear switch point
        queue_step(FUNC_ALL, 1'b1, 129, 100, 110, 900, 950, 5);
        queue_step(FUNC_ALL, 1'b1, 130, 100, 110, 900, 950, 5);
        // field extremes with zero and maximum elapsed time
        queue_step(FUNC_FRONT, 1'b1, 0, 1023, 1023, 1023, 1023, 0);
        queue_step(FUNC_BACK, 1'b0, 0, 1023, 1023, 1023, 1023, 0);
        queue_step(FUNC_ALL, 1'b1, 1023, 0, 0, 0, 0, 65535);
        queue_step(FUNC_ALL, 1'b0, 1023, 0, 0, 0, 0, 65535);
        queue_step(FUNC_FRONT, 1'b1, 1023, 1023, 1023, 1023, 1023, 1);
        // saturate efforts so the integrators freeze
        repeat (3) queue_step(FUNC_FRONT, 1'b0, 1023, 0, 0, 0, 0, 20);
        repeat (2) queue_step(FUNC_BACK, 1'b1, 1023, 0, 0, 0, 0, 20);
        queue_step(FUNC_SPARE, 1'b1, 1023, 0, 0, 0, 0, 0);
        wait_drained();

        // random part, one gain setting per phase
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin gp = 16'h7fff; gi = 16'h7fff; gd = 16'h7fff; end
                1: begin gp = 16'h8000; gi = 16'h8000; gd = 16'h8000; end
                2: begin gp = 16'h0000; gi = 16'h0000; gd = 16'h0000; end
                3: begin gp = 16'sd256; gi = 16'sd8;   gd = 16'sd16;  end
                4: begin gp = -16'sd300; gi = 16'sd40; gd = -16'sd5;  end
                default: begin
                    gp = 16'($urandom_range(0, 65535));
                    gi = 16'($urandom_range(0, 65535));
                    gd = 16'($urandom_range(0, 65535));
                end
            endcase
            load_gains(gp, gi, gd);
            steady = (ph == 3);
            for (int n = 0; n < RANDOM_STEPS; n++) begin
                kind = $urandom_range(0, 99);
                f = (kind < 8) ? FUNC_SPARE : modes[$urandom_range(0, 2)];
                tgt = ($urandom_range(0, 3) == 0) ? $urandom_range(120, 140)
                                                  : $urandom_range(0, 1023);
                if ($urandom_range(0, 1) == 0) begin
                    fl = int'(near(tgt));
                    fr = int'(near(tgt));
                    bl = int'(near(tgt));
                    br = int'(near(tgt));
                end
                else begin
                    fl = $urandom_range(0, 1023);
                    fr = $urandom_range(0, 1023);
                    bl = $urandom_range(0, 1023);
                    br = $urandom_range(0, 1023);
                end
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    dt = 0;
                else if (kind == 1)
                    dt = $urandom_range(0, 65535);
                else
                    dt = $urandom_range(1, 50);
                queue_step(f, 1'($urandom_range(0, 1)), tgt, fl, fr, bl, br, dt);
            end
            wait_drained();
            steady = 1'b0;
        end

        repeat (80) @(posedge clk);
        $display("ran %0d step requests, %0d results checked, %0d gain settings",
                 steps_taken, results_seen, gain_settings);
        $display("modes front/rear/all/spare, both sides, extreme gains, %0d mismatches",
                 error_count);
        if (error_count == 0 && predicted_steps.size() == 0)
            $display("wall_distance_pid_controller test passed");
        else
            $display("wall_distance_pid_controller test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/wdpc_pkg.sv
rtl/wdpc_if.sv
rtl/wdpc_alu.sv
rtl/wdpc_select.sv
rtl/wall_distance_pid_controller.sv
tb/tb_wall_distance_pid_controller.sv
